@@ sv/wp_pkg.sv @@
// wp_pkg: shared types and constants for the 1-D window pooling block.
// Holds default parameter values, configuration register indexes, the sequencer
// state type and the divider status struct. No dependencies.
package wp_pkg;

  localparam int KERNEL_MAX_DEF  = 32;
  localparam int COLUMN_MAX_DEF  = 65536;
  localparam int SAMPLE_BITS_DEF = 16;

  // A single request yields at most this many results.
  localparam int RESULTS_CAP = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int KERNEL_W   = 6;
  localparam int PAD_W      = 5;
  localparam int POOLED_W   = 16;
  localparam int POSITION_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MODE    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_WALK,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE,
    ST_LOAD,
    ST_FINISH
  } wp_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } wp_div_stat_t;

endpackage

@@ sv/wp_ram.sv @@
// wp_ram: generic single-write, single-read RAM with registered read data.
// No package dependencies.
module wp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/wp_div.sv @@
// wp_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on wp_pkg for the status struct.
module wp_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DIVIDEND_W-1:0]   dividend_i,
  input  logic [DIVISOR_W-1:0]    divisor_i,
  output logic [DIVIDEND_W-1:0]   quotient_o,
  output wp_pkg::wp_div_stat_t    stat_o
);
  import wp_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ sv/window_pool_1d.sv @@
// window_pool_1d: same-length 1-D max or average pooling over a sample column.
// Each result walks its window tap by tap through the single history read port and, in
// average mode, then runs the bit-serial divider (ACC_W = 22 at defaults); each request
// also passes states to accept, check and finish. A new request is taken only in idle,
// once the current one has loaded its last result and finished.
// Reset (async, active low) clears control state and loads kernel 1, pad 0, average mode.
module window_pool_1d #(
  parameter int KERNEL_MAX  = wp_pkg::KERNEL_MAX_DEF,
  parameter int COLUMN_MAX  = wp_pkg::COLUMN_MAX_DEF,
  parameter int SAMPLE_BITS = wp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [wp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          column_last_i,
  // pooled results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [wp_pkg::POOLED_W-1:0]  pooled_o,
  output logic [wp_pkg::POSITION_W-1:0] position_o,
  output logic                          run_end_o,
  output logic                          column_end_o
);
  import wp_pkg::*;

  // Widths derived from the parameters.
  localparam int AW     = $clog2(KERNEL_MAX);        // history slot index
  localparam int KW     = $clog2(KERNEL_MAX + 1);    // effective kernel size
  localparam int PW     = $clog2(KERNEL_MAX);        // effective pad
  localparam int CW     = $clog2(COLUMN_MAX + 1);    // column counters
  localparam int SI_W   = CW + 2;                    // signed sample index in a window
  localparam int SUM_W  = ((CW > KW) ? CW : KW) + 1; // window-complete compare
  localparam int ACC_W  = SAMPLE_BITS + $clog2(KERNEL_MAX) + 1;
  localparam int CAP_W  = $clog2(RESULTS_CAP + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers and their saturated views
  // ---------------------------------------------------------------------------
  logic [KERNEL_W-1:0] kern_q;
  logic [PAD_W-1:0]    pad_q;
  logic                max_q;
  logic [KW-1:0]       kern_eff;
  logic [PW-1:0]       pad_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q <= KERNEL_W'(1);
      pad_q  <= '0;
      max_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KERNEL_SIZE: kern_q <= cfg_data_i[KERNEL_W-1:0];
        CFG_PAD_LEFT:    pad_q  <= cfg_data_i[PAD_W-1:0];
        CFG_MAX_MODE:    max_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Zero kernel acts as one; clamp kernel and pad to what history can hold.
  always_comb begin
    if (kern_q == '0) begin
      kern_eff = KW'(1);
    end else if (32'(kern_q) > 32'(KERNEL_MAX)) begin
      kern_eff = KW'(KERNEL_MAX);
    end else begin
      kern_eff = KW'(kern_q);
    end
    if (32'(pad_q) > 32'(KERNEL_MAX - 1)) begin
      pad_eff = PW'(KERNEL_MAX - 1);
    end else begin
      pad_eff = PW'(pad_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  wp_state_e state_q, state_d;

  logic [CW-1:0]    ss_q, ss_d;        // samples seen in this column
  logic [CW-1:0]    sent_q, sent_d;    // outputs emitted in this column
  logic [AW-1:0]    wr_slot_q, wr_slot_d;
  logic [AW-1:0]    out_slot_q, out_slot_d;
  logic [CAP_W-1:0] cnt_q, cnt_d;      // results of the current request
  logic             last_q, last_d;
  logic             pend_q, pend_d;    // a computed result waits for the output register
  logic             next_ok_q, next_ok_d;

  logic [AW-1:0]    rd_addr_q, rd_addr_d;
  logic signed [SI_W-1:0] si_q, si_d;
  logic [KW-1:0]    k_q, k_d;

  logic             tap_vld_q, tap_in_q, tap_first_q;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [SAMPLE_BITS-1:0]  res_q, res_d;
  logic [CW-1:0]           pend_pos_q, pend_pos_d;
  logic                    pend_col_q, pend_col_d;

  logic                    out_valid_q, out_valid_d;
  logic [POOLED_W-1:0]     pooled_q, pooled_d;
  logic [POSITION_W-1:0]   position_q, position_d;
  logic                    run_end_q, run_end_d;
  logic                    col_end_q, col_end_d;

  logic in_acc;
  logic out_acc;
  logic out_free;
  logic can_emit;
  logic tap_in_d;
  logic ram_re;
  logic div_start;

  logic [SAMPLE_BITS-1:0]  ram_rdata;
  logic signed [ACC_W-1:0] tap_val;
  logic [ACC_W-1:0]        acc_mag;
  logic [ACC_W-1:0]        quotient;
  logic [ACC_W-1:0]        avg_val;
  logic [AW:0]             start_wrap;
  logic [AW-1:0]           start_addr;
  logic [31:0]             pos_wide;
  logic [31:0]             pool_wide;
  wp_div_stat_t            div_stat;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next output exists once its window is complete, or the column has ended;
  // the per-request cap holds the rest back.
  assign can_emit = (32'(cnt_q) < 32'(RESULTS_CAP)) && (sent_q < ss_q) &&
                    (last_q ||
                     (SUM_W'(sent_q) + SUM_W'(kern_eff) <= SUM_W'(ss_q) + SUM_W'(pad_eff)));

  // First slot of the window: output slot minus pad, wrapped into history.
  assign start_wrap = {1'b0, out_slot_q} + (AW + 1)'(KERNEL_MAX) - (AW + 1)'(pad_eff);
  assign start_addr = (32'(out_slot_q) >= 32'(pad_eff)) ?
                      AW'(out_slot_q - AW'(pad_eff)) : start_wrap[AW-1:0];

  // Padding and not-yet-seen positions read as zero.
  assign tap_in_d = (si_q >= 0) && (si_q < $signed(SI_W'(ss_q)));
  assign tap_val  = tap_in_q ? ACC_W'($signed(ram_rdata)) : '0;

  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign avg_val = acc_q[ACC_W-1] ? ACC_W'(~quotient + ACC_W'(1)) : quotient;

  assign ram_re    = (state_q == ST_WALK);
  assign div_start = (state_q == ST_DIV_GO);

  assign pos_wide  = 32'(pend_pos_q);
  assign pool_wide = 32'(res_q);

  always_comb begin
    state_d     = state_q;
    ss_d        = ss_q;
    sent_d      = sent_q;
    wr_slot_d   = wr_slot_q;
    out_slot_d  = out_slot_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    pend_d      = pend_q;
    next_ok_d   = next_ok_q;
    rd_addr_d   = rd_addr_q;
    si_d        = si_q;
    k_d         = k_q;
    acc_d       = acc_q;
    res_d       = res_q;
    pend_pos_d  = pend_pos_q;
    pend_col_d  = pend_col_q;
    out_valid_d = out_valid_q && !out_acc;
    pooled_d    = pooled_q;
    position_d  = position_q;
    run_end_d   = run_end_q;
    col_end_d   = col_end_q;

    // Fold the tap read in the previous cycle into the accumulator.
    if (tap_vld_q) begin
      if (tap_first_q) begin
        acc_d = tap_val;
      end else if (max_q) begin
        acc_d = (tap_val > acc_q) ? tap_val : acc_q;
      end else begin
        acc_d = acc_q + tap_val;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          // Store the sample and decide whether it closes the column.
          ss_d      = ss_q + CW'(1);
          wr_slot_d = (wr_slot_q == AW'(KERNEL_MAX - 1)) ? '0 : wr_slot_q + AW'(1);
          last_d    = column_last_i || (ss_q + CW'(1) == CW'(COLUMN_MAX));
          cnt_d     = '0;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (pend_q) begin
          // The check now tells whether the pending result ends the run.
          next_ok_d = can_emit;
          state_d   = ST_LOAD;
        end else if (can_emit) begin
          state_d = ST_START;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_START: begin
        rd_addr_d = start_addr;
        si_d      = $signed(SI_W'(sent_q)) - $signed(SI_W'(pad_eff));
        k_d       = '0;
        state_d   = ST_WALK;
      end
      ST_WALK: begin
        // Advance one tap per cycle through the single read port.
        rd_addr_d = (rd_addr_q == AW'(KERNEL_MAX - 1)) ? '0 : rd_addr_q + AW'(1);
        si_d      = si_q + SI_W'(1);
        k_d       = k_q + KW'(1);
        if (k_q == kern_eff - KW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = max_q ? ST_DONE : ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_d      = max_q ? acc_q[SAMPLE_BITS-1:0] : avg_val[SAMPLE_BITS-1:0];
        pend_pos_d = sent_q;
        pend_col_d = last_q && (sent_q + CW'(1) == ss_q);
        pend_d     = 1'b1;
        sent_d     = sent_q + CW'(1);
        out_slot_d = (out_slot_q == AW'(KERNEL_MAX - 1)) ? '0 : out_slot_q + AW'(1);
        cnt_d      = cnt_q + CAP_W'(1);
        state_d    = ST_CHECK;
      end
      ST_LOAD: begin
        // Hold until the output register frees up, then hand the result over.
        if (out_free) begin
          out_valid_d = 1'b1;
          pooled_d    = pool_wide[POOLED_W-1:0];
          position_d  = pos_wide[POSITION_W-1:0];
          run_end_d   = !next_ok_q;
          col_end_d   = pend_col_q;
          pend_d      = 1'b0;
          state_d     = next_ok_q ? ST_START : ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Drop the column counters at the column end; history is kept.
        if (last_q) begin
          ss_d       = '0;
          sent_d     = '0;
          wr_slot_d  = '0;
          out_slot_d = '0;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ss_q        <= '0;
      sent_q      <= '0;
      wr_slot_q   <= '0;
      out_slot_q  <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      pend_q      <= 1'b0;
      next_ok_q   <= 1'b0;
      tap_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ss_q        <= ss_d;
      sent_q      <= sent_d;
      wr_slot_q   <= wr_slot_d;
      out_slot_q  <= out_slot_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      pend_q      <= pend_d;
      next_ok_q   <= next_ok_d;
      tap_vld_q   <= ram_re;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q   <= rd_addr_d;
    si_q        <= si_d;
    k_q         <= k_d;
    tap_in_q    <= tap_in_d;
    tap_first_q <= (k_q == '0);
    acc_q       <= acc_d;
    res_q       <= res_d;
    pend_pos_q  <= pend_pos_d;
    pend_col_q  <= pend_col_d;
    pooled_q    <= pooled_d;
    position_q  <= position_d;
    run_end_q   <= run_end_d;
    col_end_q   <= col_end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pooled_o     = pooled_q;
  assign position_o   = position_q;
  assign run_end_o    = run_end_q;
  assign column_end_o = col_end_q;

  // ---------------------------------------------------------------------------
  // History memory and the shared divider
  // ---------------------------------------------------------------------------
  wp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (KERNEL_MAX)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (wr_slot_q),
    .wdata_i (sample_i),
    .re_i    (ram_re),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  wp_div #(
    .DIVIDEND_W (ACC_W),
    .DIVISOR_W  (KW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_mag),
    .divisor_i  (kern_eff),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_sent_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_q <= ss_q)
    else $error("more outputs emitted than samples seen");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(RESULTS_CAP))
    else $error("result count over the per-request cap");

  a_col_end_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && column_end_o |-> run_end_o)
    else $error("column end without run end");

  a_no_pend_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !pend_q)
    else $error("request taken while a result is still pending");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_stat.busy)
    else $error("divider did not start");

endmodule
